>>> sv/dsd_pkg.sv
// Package: word types, glyph geometry and the digit font table.
package dsd_pkg;

    localparam int GLYPH_COLUMNS = 6;
    localparam int GLYPH_ROWS    = 8;
    localparam int FONT_COLS     = 5;
    localparam int COL_W         = $clog2(GLYPH_COLUMNS);
    localparam int ROW_W         = $clog2(GLYPH_ROWS);

    localparam logic [3:0] BLANK_CODE   = 4'd10;
    localparam logic [3:0] UNKNOWN_CODE = 4'd11;

    localparam logic [7:0] FONT_ROM [0:10][0:FONT_COLS-1] = '{
        '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E},
        '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
        '{8'h72, 8'h49, 8'h49, 8'h49, 8'h46},
        '{8'h21, 8'h41, 8'h49, 8'h4D, 8'h33},
        '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10},
        '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
        '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h31},
        '{8'h41, 8'h21, 8'h11, 8'h09, 8'h07},
        '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36},
        '{8'h46, 8'h49, 8'h49, 8'h29, 8'h1E},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    typedef struct packed {
        logic [3:0] new_glyph;
        logic [3:0] prev_glyph;
        logic [7:0] origin_x;
        logic [7:0] origin_y;
    } in_word_t;

    typedef struct packed {
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic       paint;
        logic       last_cmd;
    } out_word_t;

    // one scanned cell of the glyph
    typedef struct packed {
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic       paint;
        logic       emit;
        logic       tail;
    } cell_t;

    // column byte of a glyph; codes above blank draw blank, spacing column is empty
    function automatic logic [7:0] font_col(logic [3:0] glyph, logic [COL_W-1:0] col);
        logic [3:0] g;
        logic [7:0] bits;
        g = (glyph > BLANK_CODE) ? BLANK_CODE : glyph;
        if (col >= COL_W'(FONT_COLS))
        begin
            bits = 8'h00;
        end
        else
        begin
            bits = FONT_ROM[g][col];
        end
        return bits;
    endfunction

endpackage

>>> sv/dsd_scan.sv
// Cell scanner: column shift registers stepping one font bit per cycle while cell_ready is high.
module dsd_scan
    import dsd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  in_word_t start_word,
    output logic     idle,
    output logic     cell_valid,
    input  logic     cell_ready,
    output cell_t    scan_cell
);

    typedef enum logic {IDLE, RUN} state_t;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(GLYPH_COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_ROWS - 1);

    state_t           state_reg, state_next;
    logic [3:0]       new_reg, new_next;
    logic [3:0]       prev_reg, prev_next;
    logic             redraw_reg, redraw_next;
    logic [7:0]       x_reg, x_next;
    logic [7:0]       y_reg, y_next;
    logic [7:0]       oy_reg, oy_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [7:0]       now_sr_reg, now_sr_next;
    logic [7:0]       old_sr_reg, old_sr_next;
    logic             start_redraw;

    assign start_redraw = (start_word.prev_glyph >= UNKNOWN_CODE);

    always_comb
    begin
        state_next  = state_reg;
        new_next    = new_reg;
        prev_next   = prev_reg;
        redraw_next = redraw_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        oy_next     = oy_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        now_sr_next = now_sr_reg;
        old_sr_next = old_sr_reg;
        unique case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    state_next  = RUN;
                    new_next    = start_word.new_glyph;
                    prev_next   = start_word.prev_glyph;
                    redraw_next = start_redraw;
                    x_next      = start_word.origin_x;
                    y_next      = start_word.origin_y;
                    oy_next     = start_word.origin_y;
                    col_next    = '0;
                    row_next    = '0;
                    now_sr_next = font_col(start_word.new_glyph, '0);
                    old_sr_next = start_redraw ? 8'h00 : font_col(start_word.prev_glyph, '0);
                end
            end
            RUN:
            begin
                if (cell_ready)
                begin
                    if (row_reg == ROW_LAST)
                    begin
                        if (col_reg == COL_LAST)
                        begin
                            state_next = IDLE;
                        end
                        else
                        begin
                            col_next    = col_reg + 1'b1;
                            row_next    = '0;
                            x_next      = x_reg + 8'd2;
                            y_next      = oy_reg;
                            now_sr_next = font_col(new_reg, col_reg + 1'b1);
                            old_sr_next = redraw_reg ? 8'h00
                                                     : font_col(prev_reg, col_reg + 1'b1);
                        end
                    end
                    else
                    begin
                        row_next    = row_reg + 1'b1;
                        y_next      = y_reg + 8'd2;
                        now_sr_next = {1'b0, now_sr_reg[7:1]};
                        old_sr_next = {1'b0, old_sr_reg[7:1]};
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            new_reg    <= '0;
            prev_reg   <= '0;
            redraw_reg <= 1'b0;
            x_reg      <= '0;
            y_reg      <= '0;
            oy_reg     <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            now_sr_reg <= '0;
            old_sr_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            new_reg    <= new_next;
            prev_reg   <= prev_next;
            redraw_reg <= redraw_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            oy_reg     <= oy_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            now_sr_reg <= now_sr_next;
            old_sr_reg <= old_sr_next;
        end
    end

    assign idle              = (state_reg == IDLE);
    assign cell_valid        = (state_reg == RUN);
    assign scan_cell.pixel_x = x_reg;
    assign scan_cell.pixel_y = y_reg;
    assign scan_cell.paint   = now_sr_reg[0];
    assign scan_cell.emit    = redraw_reg | (now_sr_reg[0] ^ old_sr_reg[0]);
    assign scan_cell.tail    = (row_reg == ROW_LAST) && (col_reg == COL_LAST);

endmodule

>>> sv/dsd_tail.sv
// Output stage: one-word hold-back so the final command of a glyph carries last_cmd.
module dsd_tail
    import dsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cell_valid,
    output logic      cell_ready,
    input  cell_t     scan_cell,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    logic      pend_valid_reg, pend_valid_next;
    out_word_t pend_reg, pend_next;
    logic      flush_reg, flush_next;
    logic      out_valid_reg, out_valid_next;
    out_word_t out_reg, out_next;
    logic      slot_free;
    logic      take;
    out_word_t cell_word;

    assign slot_free  = !out_valid_reg || out_ready;
    assign cell_ready = slot_free && !flush_reg;
    assign take       = cell_valid && cell_ready;

    assign cell_word.pixel_x  = scan_cell.pixel_x;
    assign cell_word.pixel_y  = scan_cell.pixel_y;
    assign cell_word.paint    = scan_cell.paint;
    assign cell_word.last_cmd = 1'b0;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        flush_next      = flush_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        if (flush_reg && slot_free)
        begin
            out_valid_next    = 1'b1;
            out_next          = pend_reg;
            out_next.last_cmd = 1'b1;
            pend_valid_next   = 1'b0;
            flush_next        = 1'b0;
        end
        else if (take)
        begin
            if (scan_cell.emit)
            begin
                if (pend_valid_reg)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    pend_next       = cell_word;
                    flush_next      = scan_cell.tail;
                end
                else if (scan_cell.tail)
                begin
                    out_valid_next    = 1'b1;
                    out_next          = cell_word;
                    out_next.last_cmd = 1'b1;
                end
                else
                begin
                    pend_valid_next = 1'b1;
                    pend_next       = cell_word;
                end
            end
            else if (scan_cell.tail && pend_valid_reg)
            begin
                out_valid_next    = 1'b1;
                out_next          = pend_reg;
                out_next.last_cmd = 1'b1;
                pend_valid_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            flush_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
            flush_reg      <= flush_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

>>> sv/double_size_digit_pixel_generator_unit.sv
// Top level: double-size digit pixel generator, scanner plus output stage.
// Throughput: one word per glyph; a glyph scans 6 x 8 cells, one cell a cycle while the output
//   stage takes cells, and the next word is taken only once the scan of the previous one is done.
// Output: the final command carries last_cmd; when the final cell emits behind a held command,
//   the held one goes out first and the final one is flushed from the hold register; other
//   commands wait for the next emitted cell of the glyph. A stalled output freezes the scan.
// Reset: asynchronous, active low; clears scanner state and output valid.
module double_size_digit_pixel_generator_unit
    import dsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    logic  scan_idle;
    logic  cell_valid;
    logic  cell_ready;
    cell_t scan_cell;
    logic  in_fire;

    assign in_ready = scan_idle;
    assign in_fire  = in_valid && in_ready;

    dsd_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_fire),
        .start_word (in_word),
        .idle       (scan_idle),
        .cell_valid (cell_valid),
        .cell_ready (cell_ready),
        .scan_cell  (scan_cell)
    );

    dsd_tail u_tail (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_valid (cell_valid),
        .cell_ready (cell_ready),
        .scan_cell  (scan_cell),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_word   (out_word)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("scanner not busy after accepting a word");

    a_idle_after_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid && cell_ready && scan_cell.tail) |=> in_ready)
        else $error("scanner not idle after final cell");

    a_no_cell_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !cell_valid)
        else $error("cell presented while scanner idle");

endmodule

>>> tb/tb_double_size_digit_pixel_generator_unit.sv
// Testbench for the double-size digit pixel generator: directed table plus random glyph traffic.
module tb_double_size_digit_pixel_generator_unit
    import dsd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_GLYPHS  = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_AFTER     = 40;
    localparam int HOLD_CYCLES    = 500;
    localparam int DRAIN_CYCLES   = 60;
    localparam int PRINT_CAP      = 40;
    localparam int SCREEN_SLOTS   = 4;

    localparam logic [3:0] TOP_CODE = 4'hF;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_e;

    typedef struct packed {
        in_word_t   word;
        logic       typed;
        logic [5:0] count;
    } glyph_case_t;

    localparam logic [7:0] DIGIT_FONT_COLS [0:10][0:4] = '{
        '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E},
        '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
        '{8'h72, 8'h49, 8'h49, 8'h49, 8'h46},
        '{8'h21, 8'h41, 8'h49, 8'h4D, 8'h33},
        '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10},
        '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
        '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h31},
        '{8'h41, 8'h21, 8'h11, 8'h09, 8'h07},
        '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36},
        '{8'h46, 8'h49, 8'h49, 8'h29, 8'h1E},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    // count typed only where obvious: full redraw is 48, unchanged glyph is 0
    localparam glyph_case_t DIRECTED_GLYPHS [0:21] = '{
        '{'{BLANK_CODE, UNKNOWN_CODE, 8'd0, 8'd0}, 1'b1, 6'd48},
        '{'{4'd8, UNKNOWN_CODE, 8'd255, 8'd255}, 1'b1, 6'd48},
        '{'{4'd0, UNKNOWN_CODE, 8'd128, 8'd64}, 1'b1, 6'd48},
        '{'{4'd1, UNKNOWN_CODE, 8'd250, 8'd250}, 1'b1, 6'd48},
        '{'{4'd2, TOP_CODE, 8'd7, 8'd200}, 1'b1, 6'd48},
        '{'{4'd3, 4'd12, 8'd0, 8'd255}, 1'b1, 6'd48},
        '{'{4'd4, UNKNOWN_CODE, 8'd255, 8'd0}, 1'b1, 6'd48},
        '{'{4'd5, 4'd5, 8'd10, 8'd10}, 1'b1, 6'd0},
        '{'{BLANK_CODE, BLANK_CODE, 8'd0, 8'd0}, 1'b1, 6'd0},
        '{'{TOP_CODE, BLANK_CODE, 8'd100, 8'd100}, 1'b1, 6'd0},
        '{'{4'd13, 4'd14, 8'hAA, 8'h55}, 1'b1, 6'd48},
        '{'{4'd6, UNKNOWN_CODE, 8'd33, 8'd77}, 1'b1, 6'd48},
        '{'{4'd7, 4'd6, 8'd33, 8'd77}, 1'b0, 6'd0},
        '{'{4'd8, 4'd7, 8'd33, 8'd77}, 1'b0, 6'd0},
        '{'{4'd9, 4'd8, 8'd33, 8'd77}, 1'b0, 6'd0},
        '{'{4'd0, 4'd9, 8'd33, 8'd77}, 1'b0, 6'd0},
        '{'{BLANK_CODE, 4'd0, 8'd251, 8'd249}, 1'b0, 6'd0},
        '{'{4'd1, 4'd7, 8'h55, 8'hAA}, 1'b0, 6'd0},
        '{'{4'd9, UNKNOWN_CODE, 8'h0F, 8'hF0}, 1'b1, 6'd48},
        '{'{4'd12, 4'd8, 8'd2, 8'd254}, 1'b0, 6'd0},
        '{'{4'd4, 4'd4, 8'd255, 8'd255}, 1'b1, 6'd0},
        '{'{4'd2, 4'd3, 8'd128, 8'd128}, 1'b0, 6'd0}
    };

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_word;

    out_word_t pending_pixel_cmds[$];
    out_word_t want;
    int        errors;
    int        glyphs_sent;
    int        cmds_checked;
    int        full_redraws;
    int        silent_glyphs;
    int        burst_left;
    int        idle_cycles;
    bit        draining;
    bit        hold_done;

    double_size_digit_pixel_generator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        errors++;
        if (errors <= PRINT_CAP)
        begin
            $display("%0t ns mismatch %s: got %0h, want %0h", $time, what, got, exp_val);
        end
    endtask

    // queues the commands one glyph word produces, returns how many
    function automatic int predict_pixel_cmds(input in_word_t w);
        logic       redraw;
        logic [3:0] now_g;
        logic [3:0] old_g;
        logic [7:0] now_bits;
        logic [7:0] old_bits;
        out_word_t  cmd;
        out_word_t  held;
        bit         have_held;
        int         n;
        redraw    = (w.prev_glyph >= UNKNOWN_CODE);
        now_g     = (w.new_glyph > BLANK_CODE) ? BLANK_CODE : w.new_glyph;
        old_g     = (w.prev_glyph > BLANK_CODE) ? BLANK_CODE : w.prev_glyph;
        have_held = 1'b0;
        held      = '0;
        n         = 0;
        for (int c = 0; c < GLYPH_COLUMNS; c++)
        begin
            now_bits = (c < FONT_COLS) ? DIGIT_FONT_COLS[now_g][c] : 8'h00;
            old_bits = (redraw || c >= FONT_COLS) ? 8'h00 : DIGIT_FONT_COLS[old_g][c];
            for (int r = 0; r < GLYPH_ROWS; r++)
            begin
                if (redraw || now_bits[r] != old_bits[r])
                begin
                    cmd.pixel_x  = w.origin_x + 8'(2 * c);
                    cmd.pixel_y  = w.origin_y + 8'(2 * r);
                    cmd.paint    = now_bits[r];
                    cmd.last_cmd = 1'b0;
                    if (have_held)
                    begin
                        pending_pixel_cmds.push_back(held);
                    end
                    held      = cmd;
                    have_held = 1'b1;
                    n++;
                end
            end
        end
        if (have_held)
        begin
            held.last_cmd = 1'b1;
            pending_pixel_cmds.push_back(held);
        end
        return n;
    endfunction

    // holds valid until taken; lowers it only when a gap follows
    task automatic send_glyph(input in_word_t w, output int n);
        int gap;
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        glyphs_sent++;
        n = predict_pixel_cmds(w);
        if (w.prev_glyph >= UNKNOWN_CODE)
        begin
            full_redraws++;
        end
        if (n == 0)
        begin
            silent_glyphs++;
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap        = $urandom_range(1, 12);
            burst_left = $urandom_range(0, 30);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        rx_mode_e mode;
        int       stretch;
        int       hold_left;
        out_ready = 1'b0;
        hold_left = 0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            stretch = $urandom_range(20, 200);
            mode    = rx_mode_e'($urandom_range(0, 3));
            for (int k = 0; k < stretch; k++)
            begin
                @(posedge clk);
                if (draining)
                begin
                    out_ready <= 1'b1;
                end
                else if (!hold_done && glyphs_sent >= HOLD_AFTER)
                begin
                    hold_done = 1'b1;
                    hold_left = HOLD_CYCLES;
                    out_ready <= 1'b0;
                end
                else if (hold_left > 0)
                begin
                    hold_left--;
                    out_ready <= 1'b0;
                end
                else
                begin
                    case (mode)
                        RX_OPEN:   out_ready <= 1'b1;
                        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                        default:   out_ready <= (k % 3 != 0);
                    endcase
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixel_cmds.size() == 0)
            begin
                report_mismatch("unexpected command, pixel_x", out_word.pixel_x, 0);
            end
            else
            begin
                want = pending_pixel_cmds.pop_front();
                cmds_checked++;
                if (out_word.pixel_x !== want.pixel_x)
                    report_mismatch("pixel_x", out_word.pixel_x, want.pixel_x);
                if (out_word.pixel_y !== want.pixel_y)
                    report_mismatch("pixel_y", out_word.pixel_y, want.pixel_y);
                if (out_word.paint !== want.paint)
                    report_mismatch("paint", out_word.paint, want.paint);
                if (out_word.last_cmd !== want.last_cmd)
                    report_mismatch("last_cmd", out_word.last_cmd, want.last_cmd);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: %0d cycles without a word moving", idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        in_word_t   w;
        int         n;
        int         pick;
        int         slot;
        logic [3:0] shown [0:SCREEN_SLOTS-1];
        logic [7:0] slot_x [0:SCREEN_SLOTS-1];
        logic [7:0] slot_y [0:SCREEN_SLOTS-1];
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_word       = '0;
        errors        = 0;
        glyphs_sent   = 0;
        cmds_checked  = 0;
        full_redraws  = 0;
        silent_glyphs = 0;
        burst_left    = 0;
        idle_cycles   = 0;
        draining      = 1'b0;
        hold_done     = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_GLYPHS[i])
        begin
            send_glyph(DIRECTED_GLYPHS[i].word, n);
            if (DIRECTED_GLYPHS[i].typed && n != int'(DIRECTED_GLYPHS[i].count))
                report_mismatch("command count", n, DIRECTED_GLYPHS[i].count);
        end

        for (int s = 0; s < SCREEN_SLOTS; s++)
        begin
            shown[s]  = UNKNOWN_CODE;
            slot_x[s] = 8'($urandom);
            slot_y[s] = 8'($urandom);
        end

        for (int i = 0; i < RANDOM_GLYPHS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                // a digit display being updated in place
                slot = $urandom_range(0, SCREEN_SLOTS - 1);
                if ($urandom_range(0, 19) == 0)
                begin
                    shown[slot]  = UNKNOWN_CODE;
                    slot_x[slot] = 8'($urandom);
                    slot_y[slot] = 8'($urandom);
                end
                if (shown[slot] < BLANK_CODE && $urandom_range(0, 1))
                    w.new_glyph = (shown[slot] == 4'd9) ? 4'd0 : shown[slot] + 4'd1;
                else
                    w.new_glyph = 4'($urandom_range(0, BLANK_CODE));
                w.prev_glyph = shown[slot];
                w.origin_x   = slot_x[slot];
                w.origin_y   = slot_y[slot];
                shown[slot]  = w.new_glyph;
            end
            else if (pick < 85)
            begin
                w.new_glyph  = 4'($urandom);
                w.prev_glyph = 4'($urandom_range(UNKNOWN_CODE, TOP_CODE));
                w.origin_x   = 8'($urandom);
                w.origin_y   = 8'($urandom);
            end
            else
            begin
                w = in_word_t'(24'($urandom));
            end
            send_glyph(w, n);
        end

        in_valid <= 1'b0;
        draining = 1'b1;
        while (pending_pixel_cmds.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d glyph words: %0d full redraws, %0d with nothing to change",
                 glyphs_sent, full_redraws, silent_glyphs);
        $display("checked %0d pixel commands, %0d mismatches", cmds_checked, errors);
        if (errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
